// ===== src/gate_controller_with_code_lock_unit_assert.svh =====
// assertion macros for the gate controller with code lock
// used by the top level only, expects aclk and aresetn in scope
`ifndef GATE_CONTROLLER_WITH_CODE_LOCK_UNIT_ASSERT_SVH
`define GATE_CONTROLLER_WITH_CODE_LOCK_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define GCLU_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define GCLU_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gclu_pkg.sv =====
// shared types, constants and helper functions of the gate controller with code lock
// no dependencies
package gclu_pkg;

    localparam int NUM_CODES     = 4;
    localparam int NUM_CODE_REGS = 4;
    localparam int NUM_CMP       = (NUM_CODES < NUM_CODE_REGS) ? NUM_CODES : NUM_CODE_REGS;
    localparam int CODE_DIGITS   = 4;
    localparam int DIGIT_W       = 4;
    localparam int CODE_W        = 16;
    localparam int TICK_W        = 24;
    localparam int POS_W         = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam int KEY_W         = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;
    localparam int STATE_W       = 2;
    localparam int RESULT_W      = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ZERO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd4;

    localparam logic [NUM_CODE_REGS-1:0][CODE_W-1:0] CODE_RESET =
        {16'h0123, 16'h0000, 16'h0102, 16'h1111};
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd1000000;
    localparam logic [TICK_W-1:0] TICK_MAX      = '1;

    localparam logic [DIGIT_W-1:0] DIGIT_NOT_ENTERED = 4'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_BAD         = 4'd11;

    // gate state codes as seen on the result channel
    localparam logic [STATE_W-1:0] GATE_CLOSED  = 2'd0;
    localparam logic [STATE_W-1:0] GATE_OPENING = 2'd1;
    localparam logic [STATE_W-1:0] GATE_OPEN    = 2'd2;
    localparam logic [STATE_W-1:0] GATE_CLOSING = 2'd3;

    // code check outcome codes
    localparam logic [RESULT_W-1:0] RESULT_NONE   = 2'd0;
    localparam logic [RESULT_W-1:0] RESULT_MATCH  = 2'd1;
    localparam logic [RESULT_W-1:0] RESULT_REJECT = 2'd2;

    typedef enum logic [3:0] {
        MODE_CLOSED  = 4'b0001,
        MODE_OPENING = 4'b0010,
        MODE_OPEN    = 4'b0100,
        MODE_CLOSING = 4'b1000
    } gate_mode_t;

    typedef struct packed {
        logic             open_button;
        logic             close_button;
        logic             open_limit;
        logic             closed_limit;
        logic             obstacle;
        logic             key_pressed;
        logic [KEY_W-1:0] key_row;
        logic [KEY_W-1:0] key_col;
    } item_t;

    typedef struct packed {
        logic key_accepted;
        logic check_done;
        logic matched;
    } lock_status_t;

    typedef struct packed {
        logic [STATE_W-1:0]  gate_state;
        logic                key_accepted;
        logic [RESULT_W-1:0] code_result;
    } result_t;

    function automatic logic [DIGIT_W-1:0] key_digit(input logic [KEY_W-1:0] row,
                                                     input logic [KEY_W-1:0] col);
        logic [DIGIT_W-1:0] d;
        d = DIGIT_BAD;
        if (row >= 3'd1 && row <= 3'd3 && col >= 3'd1 && col <= 3'd3) begin
            d = DIGIT_W'(col) + DIGIT_W'(4'd3 * (DIGIT_W'(row) - 4'd1));
        end else if (row == 3'd4 && col == 3'd2) begin
            d = 4'd0;
        end else if (row == 3'd1 && col == 3'd4) begin
            d = 4'd0;
        end
        return d;
    endfunction

    function automatic logic [STATE_W-1:0] mode_code(input gate_mode_t m);
        logic [STATE_W-1:0] c;
        case (m)
            MODE_CLOSED:  c = GATE_CLOSED;
            MODE_OPENING: c = GATE_OPENING;
            MODE_OPEN:    c = GATE_OPEN;
            MODE_CLOSING: c = GATE_CLOSING;
            default:      c = GATE_CLOSED;
        endcase
        return c;
    endfunction

endpackage

// ===== src/gate_controller_with_code_lock_unit.sv =====
// top level of the gate controller with keypad code lock
// depends on gclu_pkg, gclu_cfg_regs, gclu_code_lock, gclu_gate_fsm and the assertion header
//
// usage
//   one input transaction per control tick on the s_ channel (valid/ready): buttons,
//   limit switches, obstacle flag and an optional key press with its row and column
//   every input transaction yields exactly one result transaction on the m_ channel:
//   new gate state, motor drives, warning lamp, key accept flag and code check outcome
//   configuration writes go through cfg_valid/cfg_ready with cfg_index and cfg_data:
//   index 0..3 are the four codes (first digit in the high nibble), 4 is the entry
//   timeout; other indexes are ignored; cfg_ready is always high, write only while idle
// pipeline
//   input register, then one pass into the result register, from which the result is
//   offered; one transaction per cycle is sustained while m_ready is high, and the gate
//   state loop closes through the mode register of the gate state machine
// reset
//   aresetn low clears both stages, puts the gate in closed, marks all digit slots as
//   not entered, rewinds the entry position, zeroes the idle counter and reloads the
//   default codes and timeout
// stalls
//   while m_ready is low the result is held; one more transaction is taken into the
//   input register, after which s_ready drops until the result moves on
`include "gate_controller_with_code_lock_unit_assert.svh"

module gate_controller_with_code_lock_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gclu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gclu_pkg::CFG_DATA_W-1:0]      cfg_data,

    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_open_button,
    input  logic                                 s_close_button,
    input  logic                                 s_open_limit,
    input  logic                                 s_closed_limit,
    input  logic                                 s_obstacle,
    input  logic                                 s_key_pressed,
    input  logic [gclu_pkg::KEY_W-1:0]           s_key_row,
    input  logic [gclu_pkg::KEY_W-1:0]           s_key_col,

    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [gclu_pkg::STATE_W-1:0]         m_gate_state,
    output logic                                 m_drive_open,
    output logic                                 m_drive_close,
    output logic                                 m_moving_lamp,
    output logic                                 m_key_accepted,
    output logic [gclu_pkg::RESULT_W-1:0]        m_code_result
);

    // pipeline control
    logic            in_valid_reg, in_valid_next;
    logic            out_valid_reg, out_valid_next;
    gclu_pkg::item_t item_reg, item_next;
    gclu_pkg::result_t res_reg, res_next;
    logic            s_take;
    logic            advance;

    // between the sub-blocks
    logic [gclu_pkg::NUM_CODE_REGS-1:0][gclu_pkg::CODE_W-1:0] codes;
    logic [gclu_pkg::TICK_W-1:0]   entry_timeout;
    gclu_pkg::lock_status_t        lock_status;
    logic                          gate_closed;
    logic [gclu_pkg::STATE_W-1:0]  gate_state_next;

    assign cfg_ready = 1'b1;

    // the held item moves on when the result slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        item_next = item_reg;
        if (s_take) begin
            item_next.open_button  = s_open_button;
            item_next.close_button = s_close_button;
            item_next.open_limit   = s_open_limit;
            item_next.closed_limit = s_closed_limit;
            item_next.obstacle     = s_obstacle;
            item_next.key_pressed  = s_key_pressed;
            item_next.key_row      = s_key_row;
            item_next.key_col      = s_key_col;
        end
        in_valid_next = s_take || (in_valid_reg && !advance);
    end

    gclu_cfg_regs u_cfg_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wr_en         (cfg_valid && cfg_ready),
        .wr_index      (cfg_index),
        .wr_data       (cfg_data),
        .codes         (codes),
        .entry_timeout (entry_timeout)
    );

    gclu_code_lock u_code_lock (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .gate_closed   (gate_closed),
        .item          (item_reg),
        .codes         (codes),
        .entry_timeout (entry_timeout),
        .status        (lock_status)
    );

    gclu_gate_fsm u_gate_fsm (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .item            (item_reg),
        .lock            (lock_status),
        .gate_closed     (gate_closed),
        .gate_state_next (gate_state_next)
    );

    // result register load
    always_comb begin
        res_next = res_reg;
        if (advance) begin
            res_next.gate_state   = gate_state_next;
            res_next.key_accepted = lock_status.key_accepted;
            if (lock_status.check_done) begin
                res_next.code_result = lock_status.matched ? gclu_pkg::RESULT_MATCH
                                                           : gclu_pkg::RESULT_REJECT;
            end else begin
                res_next.code_result = gclu_pkg::RESULT_NONE;
            end
        end
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    // drives and lamp decode straight from the registered state
    assign m_valid        = out_valid_reg;
    assign m_gate_state   = res_reg.gate_state;
    assign m_drive_open   = (res_reg.gate_state == gclu_pkg::GATE_OPENING);
    assign m_drive_close  = (res_reg.gate_state == gclu_pkg::GATE_CLOSING);
    assign m_moving_lamp  = m_drive_open || m_drive_close;
    assign m_key_accepted = res_reg.key_accepted;
    assign m_code_result  = res_reg.code_result;

    // input stage only backs up behind a stalled result
    `GCLU_ASSERT_SAME(a_stall_source, !s_ready, m_valid && !m_ready, "input blocked without output stall")

    // a matched code always starts opening, a rejected one always leaves the gate closed
    `GCLU_ASSERT_SAME(a_match_opens, m_valid && (m_code_result == gclu_pkg::RESULT_MATCH), m_gate_state == gclu_pkg::GATE_OPENING, "matched code did not open")
    `GCLU_ASSERT_SAME(a_reject_closed, m_valid && (m_code_result == gclu_pkg::RESULT_REJECT), m_gate_state == gclu_pkg::GATE_CLOSED, "rejected code left gate moving")

    // a pending item with a free result slot is delivered next cycle
    `GCLU_ASSERT_NEXT(a_advance_delivers, in_valid_reg && !m_valid, m_valid, "held item not delivered")

endmodule

// ===== src/gclu_cfg_regs.sv =====
// configuration registers: stored codes and entry timeout
// depends on gclu_pkg
module gclu_cfg_regs (
    input  logic                                                    aclk,
    input  logic                                                    aresetn,
    input  logic                                                    wr_en,
    input  logic [gclu_pkg::CFG_IDX_W-1:0]                          wr_index,
    input  logic [gclu_pkg::CFG_DATA_W-1:0]                         wr_data,
    output logic [gclu_pkg::NUM_CODE_REGS-1:0][gclu_pkg::CODE_W-1:0] codes,
    output logic [gclu_pkg::TICK_W-1:0]                             entry_timeout
);

    logic [gclu_pkg::NUM_CODE_REGS-1:0][gclu_pkg::CODE_W-1:0] codes_reg, codes_next;
    logic [gclu_pkg::TICK_W-1:0] timeout_reg, timeout_next;

    always_comb begin
        codes_next   = codes_reg;
        timeout_next = timeout_reg;
        if (wr_en) begin
            case (wr_index)
                gclu_pkg::CFG_CODE_ZERO:  codes_next[0] = wr_data[gclu_pkg::CODE_W-1:0];
                gclu_pkg::CFG_CODE_ONE:   codes_next[1] = wr_data[gclu_pkg::CODE_W-1:0];
                gclu_pkg::CFG_CODE_TWO:   codes_next[2] = wr_data[gclu_pkg::CODE_W-1:0];
                gclu_pkg::CFG_CODE_THREE: codes_next[3] = wr_data[gclu_pkg::CODE_W-1:0];
                gclu_pkg::CFG_TIMEOUT:    timeout_next = wr_data[gclu_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg   <= gclu_pkg::CODE_RESET;
            timeout_reg <= gclu_pkg::TIMEOUT_RESET;
        end else begin
            codes_reg   <= codes_next;
            timeout_reg <= timeout_next;
        end
    end

    assign codes         = codes_reg;
    assign entry_timeout = timeout_reg;

endmodule

// ===== src/gclu_code_lock.sv =====
// keypad code entry: digit slots, entry position, idle counter and code compare
// depends on gclu_pkg
module gclu_code_lock (
    input  logic                                                    aclk,
    input  logic                                                    aresetn,
    input  logic                                                    step,
    input  logic                                                    gate_closed,
    input  gclu_pkg::item_t                                         item,
    input  logic [gclu_pkg::NUM_CODE_REGS-1:0][gclu_pkg::CODE_W-1:0] codes,
    input  logic [gclu_pkg::TICK_W-1:0]                             entry_timeout,
    output gclu_pkg::lock_status_t                                  status
);

    logic [gclu_pkg::CODE_DIGITS-1:0][gclu_pkg::DIGIT_W-1:0] digits_reg, digits_next;
    logic [gclu_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [gclu_pkg::TICK_W-1:0] idle_reg, idle_next;

    logic [gclu_pkg::TICK_W-1:0]  idle_inc;
    logic [gclu_pkg::POS_W-1:0]   pos_eff;
    logic [gclu_pkg::DIGIT_W-1:0] digit;
    logic                         digit_ok;
    logic                         last_slot;
    logic [gclu_pkg::CODE_W-1:0]  entered_flat;
    logic                         matched;
    logic                         key_now;

    always_comb begin
        idle_inc = (idle_reg != gclu_pkg::TICK_MAX) ? idle_reg + 1'b1 : idle_reg;
        // timeout check comes before the key press of the same tick
        pos_eff   = (idle_inc > entry_timeout) ? '0 : pos_reg;
        digit     = gclu_pkg::key_digit(item.key_row, item.key_col);
        digit_ok  = (digit != gclu_pkg::DIGIT_BAD);
        key_now   = gate_closed && item.key_pressed;
        last_slot = (pos_eff == gclu_pkg::POS_W'(gclu_pkg::CODE_DIGITS - 1));

        digits_next = digits_reg;
        if (key_now && digit_ok) begin
            digits_next[pos_eff] = digit;
        end

        // first slot goes to the highest nibble
        for (int d = 0; d < gclu_pkg::CODE_DIGITS; d++) begin
            entered_flat[gclu_pkg::DIGIT_W*(gclu_pkg::CODE_DIGITS-1-d) +: gclu_pkg::DIGIT_W] =
                digits_next[d];
        end

        matched = 1'b0;
        for (int k = 0; k < gclu_pkg::NUM_CMP; k++) begin
            if (codes[k] == entered_flat) begin
                matched = 1'b1;
            end
        end

        pos_next  = pos_reg;
        idle_next = idle_reg;
        if (gate_closed) begin
            idle_next = item.key_pressed ? '0 : idle_inc;
            if (item.key_pressed) begin
                pos_next = last_slot ? '0 : pos_eff + 1'b1;
            end else begin
                pos_next = pos_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg <= {gclu_pkg::CODE_DIGITS{gclu_pkg::DIGIT_NOT_ENTERED}};
            pos_reg    <= '0;
            idle_reg   <= '0;
        end else if (step) begin
            digits_reg <= digits_next;
            pos_reg    <= pos_next;
            idle_reg   <= idle_next;
        end
    end

    assign status.key_accepted = key_now && digit_ok;
    assign status.check_done   = key_now && last_slot;
    assign status.matched      = matched;

endmodule

// ===== src/gclu_gate_fsm.sv =====
// gate motion state machine: closed, opening, open, closing
// depends on gclu_pkg
module gclu_gate_fsm (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  gclu_pkg::item_t                 item,
    input  gclu_pkg::lock_status_t          lock,
    output logic                            gate_closed,
    output logic [gclu_pkg::STATE_W-1:0]    gate_state_next
);

    gclu_pkg::gate_mode_t mode_reg, mode_next;

    always_comb begin
        mode_next = mode_reg;
        case (mode_reg)
            gclu_pkg::MODE_CLOSED: begin
                if (item.open_button) begin
                    mode_next = gclu_pkg::MODE_OPENING;
                end
                // a rejected code holds the gate closed even with open pressed
                if (lock.check_done) begin
                    mode_next = lock.matched ? gclu_pkg::MODE_OPENING : gclu_pkg::MODE_CLOSED;
                end
            end
            gclu_pkg::MODE_OPENING: begin
                if (item.close_button) begin
                    mode_next = gclu_pkg::MODE_CLOSING;
                end
                if (item.open_limit) begin
                    mode_next = gclu_pkg::MODE_OPEN;
                end
            end
            gclu_pkg::MODE_OPEN: begin
                if (item.close_button) begin
                    mode_next = gclu_pkg::MODE_CLOSING;
                end
            end
            gclu_pkg::MODE_CLOSING: begin
                if (item.obstacle || item.open_button) begin
                    mode_next = gclu_pkg::MODE_OPENING;
                end
                if (item.closed_limit) begin
                    mode_next = gclu_pkg::MODE_CLOSED;
                end
            end
            default: mode_next = gclu_pkg::MODE_CLOSED;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= gclu_pkg::MODE_CLOSED;
        end else if (step) begin
            mode_reg <= mode_next;
        end
    end

    assign gate_closed     = (mode_reg == gclu_pkg::MODE_CLOSED);
    assign gate_state_next = gclu_pkg::mode_code(mode_next);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for gate_controller_with_code_lock_unit: directed and random
// control ticks against an in-bench gate and code lock model; depends on gclu_pkg and the rtl

module tb;
    import gclu_pkg::*;

    // one result transaction as seen on the m_ side
    typedef struct packed {
        logic [STATE_W-1:0]  gate_state;
        logic                drive_open;
        logic                drive_close;
        logic                moving_lamp;
        logic                key_accepted;
        logic [RESULT_W-1:0] code_result;
    } tick_out_t;

    // a configuration index that maps to no register, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 340;
    localparam int DRAIN_CYCLES = 6;

    // gate state machine plus keypad code lock, predicting one result per control tick
    class gate_lock_model;
        logic [STATE_W-1:0] gate_now;
        logic [DIGIT_W-1:0] slots[CODE_DIGITS];
        int                 slot_pos;
        logic [TICK_W-1:0]  idle_ticks;
        logic [CODE_W-1:0]  codes[NUM_CODE_REGS];
        logic [TICK_W-1:0]  entry_timeout;
        tick_out_t          expected_ticks[$];
        int                 errors;

        function new();
            for (int i = 0; i < NUM_CODE_REGS; i++) codes[i] = CODE_RESET[i];
            for (int d = 0; d < CODE_DIGITS; d++) slots[d] = DIGIT_NOT_ENTERED;
            entry_timeout = TIMEOUT_RESET;
            gate_now      = GATE_CLOSED;
            slot_pos      = 0;
            idle_ticks    = '0;
            errors        = 0;
        endfunction

        static function logic [DIGIT_W-1:0] key_to_digit(logic [KEY_W-1:0] row,
                                                         logic [KEY_W-1:0] col);
            logic [DIGIT_W-1:0] dg;
            dg = DIGIT_BAD;
            if (row != 0 && row < 4 && col != 0 && col < 4) begin
                dg = DIGIT_W'(3 * row + col - 3);
            end else if ((row == 4 && col == 2) || (row == 1 && col == 4)) begin
                dg = '0;
            end
            return dg;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CODE_ZERO, CFG_CODE_ONE, CFG_CODE_TWO, CFG_CODE_THREE: begin
                    codes[idx] = data[CODE_W-1:0];
                end
                CFG_TIMEOUT: begin
                    entry_timeout = data[TICK_W-1:0];
                end
                default: ;
            endcase
        endfunction

        function bit code_hit();
            bit same;
            for (int k = 0; k < NUM_CMP; k++) begin
                same = 1'b1;
                for (int d = 0; d < CODE_DIGITS; d++) begin
                    if (codes[k][DIGIT_W*(CODE_DIGITS-1-d) +: DIGIT_W] != slots[d]) same = 1'b0;
                end
                if (same) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_tick(item_t it);
            tick_out_t          r;
            logic [STATE_W-1:0] nxt;
            logic [DIGIT_W-1:0] dg;
            r   = '0;
            nxt = gate_now;
            case (gate_now)
                GATE_CLOSED: begin
                    if (it.open_button) nxt = GATE_OPENING;
                    if (idle_ticks != TICK_MAX) idle_ticks++;
                    if (idle_ticks > entry_timeout) slot_pos = 0;
                    if (it.key_pressed) begin
                        dg = key_to_digit(it.key_row, it.key_col);
                        if (dg != DIGIT_BAD) begin
                            slots[slot_pos] = dg;
                            r.key_accepted  = 1'b1;
                        end
                        idle_ticks = '0;
                        if (slot_pos == CODE_DIGITS - 1) begin
                            if (code_hit()) begin
                                nxt           = GATE_OPENING;
                                r.code_result = RESULT_MATCH;
                            end else begin
                                nxt           = GATE_CLOSED;
                                r.code_result = RESULT_REJECT;
                            end
                            slot_pos = 0;
                        end else begin
                            slot_pos++;
                        end
                    end
                end
                GATE_OPENING: begin
                    if (it.close_button) nxt = GATE_CLOSING;
                    if (it.open_limit) nxt = GATE_OPEN;
                end
                GATE_OPEN: begin
                    if (it.close_button) nxt = GATE_CLOSING;
                end
                default: begin
                    if (it.obstacle || it.open_button) nxt = GATE_OPENING;
                    if (it.closed_limit) nxt = GATE_CLOSED;
                end
            endcase
            gate_now      = nxt;
            r.gate_state  = nxt;
            r.drive_open  = (nxt == GATE_OPENING);
            r.drive_close = (nxt == GATE_CLOSING);
            r.moving_lamp = r.drive_open | r.drive_close;
            expected_ticks.push_back(r);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_tick(tick_out_t got);
            tick_out_t want;
            if (expected_ticks.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            want = expected_ticks.pop_front();
            check_field("gate_state", want.gate_state, got.gate_state);
            check_field("drive_open", want.drive_open, got.drive_open);
            check_field("drive_close", want.drive_close, got.drive_close);
            check_field("moving_lamp", want.moving_lamp, got.moving_lamp);
            check_field("key_accepted", want.key_accepted, got.key_accepted);
            check_field("code_result", want.code_result, got.code_result);
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction
    endclass

    logic aclk;
    logic aresetn;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic               s_valid;
    logic               s_ready;
    logic               s_open_button;
    logic               s_close_button;
    logic               s_open_limit;
    logic               s_closed_limit;
    logic               s_obstacle;
    logic               s_key_pressed;
    logic [KEY_W-1:0]   s_key_row;
    logic [KEY_W-1:0]   s_key_col;

    logic                m_valid;
    logic                m_ready;
    logic [STATE_W-1:0]  m_gate_state;
    logic                m_drive_open;
    logic                m_drive_close;
    logic                m_moving_lamp;
    logic                m_key_accepted;
    logic [RESULT_W-1:0] m_code_result;

    gate_lock_model sb;

    // idling knobs, percent of cycles the receiver sits out and of ticks the sender pauses before
    int tx_idle_pct;
    int rx_idle_pct;
    // long receiver hold-off, counted down by the receiver process
    int rx_hold;
    int cycles;
    // code the random key presses are currently aiming at
    logic [CODE_W-1:0] code_goal;

    gate_controller_with_code_lock_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_open_button  (s_open_button),
        .s_close_button (s_close_button),
        .s_open_limit   (s_open_limit),
        .s_closed_limit (s_closed_limit),
        .s_obstacle     (s_obstacle),
        .s_key_pressed  (s_key_pressed),
        .s_key_row      (s_key_row),
        .s_key_col      (s_key_col),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_gate_state   (m_gate_state),
        .m_drive_open   (m_drive_open),
        .m_drive_close  (m_drive_close),
        .m_moving_lamp  (m_moving_lamp),
        .m_key_accepted (m_key_accepted),
        .m_code_result  (m_code_result)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // result side: every accepted transaction is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_tick({m_gate_state, m_drive_open, m_drive_close, m_moving_lamp,
                           m_key_accepted, m_code_result});
        end
    end

    // receiver: random back-pressure, or a long hold-off when one is requested
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // control tick from individual fields, used by the directed part
    function automatic item_t ctl(input logic ob, input logic cb, input logic ol,
                                  input logic cl, input logic obs, input logic kp,
                                  input logic [KEY_W-1:0] row, input logic [KEY_W-1:0] col);
        item_t it;
        it.open_button  = ob;
        it.close_button = cb;
        it.open_limit   = ol;
        it.closed_limit = cl;
        it.obstacle     = obs;
        it.key_pressed  = kp;
        it.key_row      = row;
        it.key_col      = col;
        return it;
    endfunction

    // row and column of a key that yields the digit, zero has two keys
    function automatic logic [2*KEY_W-1:0] key_for(input logic [DIGIT_W-1:0] dg);
        logic [KEY_W-1:0] row;
        logic [KEY_W-1:0] col;
        if (dg == 0) begin
            if ($urandom_range(1)) begin
                row = 3'd4;
                col = 3'd2;
            end else begin
                row = 3'd1;
                col = 3'd4;
            end
        end else begin
            row = KEY_W'((dg - 1) / 3 + 1);
            col = KEY_W'((dg - 1) % 3 + 1);
        end
        return {row, col};
    endfunction

    // any row/column pair that maps to no digit, out-of-range values included
    function automatic logic [2*KEY_W-1:0] bad_key();
        logic [2*KEY_W-1:0] rc;
        do begin
            rc = (2*KEY_W)'($urandom);
        end while (gate_lock_model::key_to_digit(rc[2*KEY_W-1:KEY_W], rc[KEY_W-1:0])
                   != DIGIT_BAD);
        return rc;
    endfunction

    // code with mostly typeable digits, now and then any nibble
    function automatic logic [CODE_W-1:0] rand_code();
        logic [CODE_W-1:0] c;
        for (int d = 0; d < CODE_DIGITS; d++) begin
            if ($urandom_range(99) < 10) c[DIGIT_W*d +: DIGIT_W] = DIGIT_W'($urandom_range(15));
            else c[DIGIT_W*d +: DIGIT_W] = DIGIT_W'($urandom_range(9));
        end
        return c;
    endfunction

    // random control tick shaped by the predicted gate state:
    // - a few ticks are pure noise on every field
    // - while closed most ticks type the next digit of a goal code, mostly a stored one
    // - while not closed, buttons and limit switches are pressed often enough to cycle the gate
    function automatic item_t random_tick();
        item_t            it;
        logic [11:0]      raw;
        int               roll;
        logic [DIGIT_W-1:0] want;
        raw  = 12'($urandom);
        it   = raw;
        roll = $urandom_range(99);
        if (roll < 8) return it;
        if (sb.gate_now == GATE_CLOSED) begin
            it.open_button = ($urandom_range(99) < 3);
            if (roll < 75) begin
                it.key_pressed = 1'b1;
                if (sb.slot_pos == 0) begin
                    if ($urandom_range(99) < 80) code_goal = sb.codes[$urandom_range(NUM_CODE_REGS-1)];
                    else code_goal = CODE_W'($urandom);
                end
                want = code_goal[DIGIT_W*(CODE_DIGITS-1-sb.slot_pos) +: DIGIT_W];
                // a small share keeps the raw row and column as a mistyped key
                if ($urandom_range(99) >= 6) begin
                    if (want <= 9) {it.key_row, it.key_col} = key_for(want);
                    else {it.key_row, it.key_col} = bad_key();
                end
            end else begin
                it.key_pressed = 1'b0;
            end
        end else begin
            it.open_button  = ($urandom_range(99) < 12);
            it.close_button = ($urandom_range(99) < 25);
            it.open_limit   = ($urandom_range(99) < 30);
            it.closed_limit = ($urandom_range(99) < 30);
            it.obstacle     = ($urandom_range(99) < 12);
        end
        return it;
    endfunction

    // sender: called at a falling edge, returns at the falling edge after the transaction
    task automatic send_tick(input item_t it);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_open_button  <= it.open_button;
        s_close_button <= it.close_button;
        s_open_limit   <= it.open_limit;
        s_closed_limit <= it.closed_limit;
        s_obstacle     <= it.obstacle;
        s_key_pressed  <= it.key_pressed;
        s_key_row      <= it.key_row;
        s_key_col      <= it.key_col;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(it);
        @(negedge aclk);
    endtask

    // register write, leaves cfg_valid up so back-to-back writes keep cfg_valid high between them
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    // wait until every predicted result has come out, then reprogram and run random ticks
    // code writes carry random upper data bits, which the block must drop
    task automatic run_phase(input logic [CODE_W-1:0] c0, input logic [CODE_W-1:0] c1,
                             input logic [CODE_W-1:0] c2, input logic [CODE_W-1:0] c3,
                             input logic [TICK_W-1:0] tmo, input int n);
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_write(CFG_CODE_ZERO,  {8'($urandom), c0});
        cfg_write(CFG_CODE_ONE,   {8'($urandom), c1});
        cfg_write(CFG_CODE_TWO,   {8'($urandom), c2});
        cfg_write(CFG_CODE_THREE, {8'($urandom), c3});
        cfg_write(CFG_TIMEOUT,    tmo);
        cfg_valid <= 1'b0;
        for (int i = 0; i < n; i++) send_tick(random_tick());
        s_valid <= 1'b0;
    endtask

    initial begin
        sb             = new();
        cycles         = 0;
        rx_hold        = 0;
        code_goal      = '0;
        tx_idle_pct    = 14;
        rx_idle_pct    = 71;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_open_button  = 1'b0;
        s_close_button = 1'b0;
        s_open_limit   = 1'b0;
        s_closed_limit = 1'b0;
        s_obstacle     = 1'b0;
        s_key_pressed  = 1'b0;
        s_key_row      = '0;
        s_key_col      = '0;
        m_ready        = 1'b0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // a code with not-entered nibbles, so slots never written can still match
        cfg_write(CFG_CODE_THREE, {8'hff, 16'hAAA7});
        cfg_valid <= 1'b0;

        // directed part, default codes and timeout otherwise
        send_tick(ctl(0, 0, 0, 0, 0, 0, 3'd0, 3'd0));   // nothing happens while closed
        send_tick(ctl(0, 0, 0, 0, 0, 1, 3'd0, 3'd0));   // invalid key still moves the slot
        send_tick(ctl(0, 0, 0, 0, 0, 1, 3'd7, 3'd7));
        send_tick(ctl(0, 0, 0, 0, 0, 1, 3'd4, 3'd4));
        send_tick(ctl(0, 0, 0, 0, 0, 1, 3'd3, 3'd1));   // digit 7 against stale slots, match
        send_tick(ctl(0, 1, 1, 0, 0, 0, 3'd0, 3'd0));   // open limit wins over close
        send_tick(ctl(1, 0, 1, 1, 1, 1, 3'd4, 3'd2));   // key ignored while open
        send_tick(ctl(0, 1, 0, 0, 0, 0, 3'd0, 3'd0));   // close
        send_tick(ctl(0, 0, 0, 0, 1, 0, 3'd0, 3'd0));   // obstacle reverses closing
        send_tick(ctl(0, 1, 0, 0, 0, 0, 3'd0, 3'd0));
        send_tick(ctl(1, 0, 0, 1, 1, 0, 3'd0, 3'd0));   // closed limit wins over reversal
        send_tick(ctl(0, 0, 0, 0, 0, 1, 3'd1, 3'd1));   // 1 1 1 0, no stored match
        send_tick(ctl(0, 0, 0, 0, 0, 1, 3'd1, 3'd1));
        send_tick(ctl(0, 0, 0, 0, 0, 1, 3'd1, 3'd1));
        send_tick(ctl(1, 0, 0, 0, 0, 1, 3'd1, 3'd4));   // reject holds closed despite open
        send_tick(ctl(0, 0, 0, 0, 0, 1, 3'd4, 3'd2));   // 0 1 0 2 matches the second code
        send_tick(ctl(0, 0, 0, 0, 0, 1, 3'd1, 3'd1));
        send_tick(ctl(0, 0, 0, 0, 0, 1, 3'd1, 3'd4));
        send_tick(ctl(0, 0, 0, 0, 0, 1, 3'd1, 3'd2));
        send_tick(ctl(0, 0, 1, 0, 0, 0, 3'd0, 3'd0));   // open
        send_tick(ctl(0, 1, 0, 0, 0, 0, 3'd0, 3'd0));   // closing
        send_tick(ctl(0, 0, 0, 1, 0, 0, 3'd0, 3'd0));   // closed
        send_tick(ctl(1, 0, 0, 0, 0, 1, 3'd2, 3'd3));   // open button and a key in one tick
        send_tick(ctl(0, 1, 0, 0, 0, 0, 3'd0, 3'd0));   // close while opening
        send_tick(ctl(0, 0, 0, 1, 0, 0, 3'd0, 3'd0));
        s_valid <= 1'b0;

        // random part: receiver mostly stalled first
        run_phase(rand_code(), rand_code(), rand_code(), rand_code(), 24'd5, PHASE_ITEMS);
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
        // a write to an unmapped index must change nothing
        cfg_write(CFG_UNUSED, 24'hffffff);
        cfg_valid <= 1'b0;
        run_phase(16'h0000, 16'hFFFF, 16'h9999, rand_code(), 24'd0, PHASE_ITEMS);

        // sender mostly idle
        tx_idle_pct = 71;
        rx_idle_pct = 14;
        run_phase(rand_code(), rand_code(), rand_code(), rand_code(), 24'hFFFFFF, PHASE_ITEMS);
        run_phase(rand_code(), rand_code(), rand_code(), rand_code(), 24'd1, PHASE_ITEMS);

        // full rate, opening with a long receiver hold-off so the input side backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold     = 400;
        run_phase(rand_code(), rand_code(), rand_code(), rand_code(), 24'd12, PHASE_ITEMS);
        run_phase(rand_code(), rand_code(), 16'hAAAA, rand_code(), 24'd3, PHASE_ITEMS);

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
